// File: src/hem_pkg.sv
// shared types and constants for the histogram equalization map block
// no dependencies; every other file of the block depends on this package
package hem_pkg;

  // payload widths fixed by the channel definitions
  localparam int IN_W       = 25;
  localparam int PC_W       = 25;
  localparam int EN_W       = 3;
  localparam int LVL_OUT_W  = 8;
  localparam int NUM_CH     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 2'd1;

  // configuration reset values
  localparam logic [EN_W-1:0] ENABLE_RESET      = 3'd7;
  localparam logic [PC_W-1:0] PIXEL_COUNT_RESET = 25'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic start;     // scale sums and load the dividers
    logic step;      // one quotient bit per divider
    logic out_load;  // capture the finished map entry
  } hem_cmd_t;

endpackage

// File: src/hem_hist_if.sv
// histogram bin channel: one transaction carries the three counts of one level
// depends on hem_pkg for the count width
interface hem_hist_if;
  logic                     valid;
  logic                     ready;
  logic [hem_pkg::IN_W-1:0] red_count;
  logic [hem_pkg::IN_W-1:0] green_count;
  logic [hem_pkg::IN_W-1:0] blue_count;

  modport source (output valid, red_count, green_count, blue_count, input ready);
  modport sink (input valid, red_count, green_count, blue_count, output ready);
endinterface

// File: src/hem_lut_if.sv
// map entry channel: one transaction carries the equalized levels of one input level
// depends on hem_pkg for the level width
interface hem_lut_if;
  logic                          valid;
  logic                          ready;
  logic [hem_pkg::LVL_OUT_W-1:0] level_index;
  logic [hem_pkg::LVL_OUT_W-1:0] red_level;
  logic [hem_pkg::LVL_OUT_W-1:0] green_level;
  logic [hem_pkg::LVL_OUT_W-1:0] blue_level;
  logic                          last_entry;

  modport source (output valid, level_index, red_level, green_level, blue_level, last_entry,
                  input ready);
  modport sink (input valid, level_index, red_level, green_level, blue_level, last_entry,
                output ready);
endinterface

// File: src/hem_cfg_if.sv
// configuration write channel: register index and write data
// depends on hem_pkg for the index and data widths
interface hem_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hem_pkg::CFG_IDX_W-1:0]  index;
  logic [hem_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/hem_div.sv
// scaled restoring divider: floor(MAX_LEVEL * sum / divisor), saturated at MAX_LEVEL
// one quotient bit per step; depends on hem_pkg
module hem_div #(
  parameter int MAX_LEVEL = 255,
  parameter int SUM_W     = 25
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic                            step,
  input  logic [SUM_W-1:0]                sum,
  input  logic [hem_pkg::PC_W-1:0]        divisor,
  output logic [$clog2(MAX_LEVEL+1)-1:0]  quotient
);
  import hem_pkg::*;

  localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int PROD_W = SUM_W + LVL_W;
  localparam int REM_W  = ((SUM_W > PC_W) ? SUM_W : PC_W) + 1;
  localparam logic [LVL_W-1:0] MaxCode = LVL_W'(MAX_LEVEL);

  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  trial;
  logic [LVL_W-1:0]  low;
  logic [LVL_W-1:0]  q;
  logic              sat;
  logic              fits;

  // constant scaling of the cumulative sum
  assign prod = PROD_W'(sum) * PROD_W'(MAX_LEVEL);

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem[REM_W-2:0], low[LVL_W-1]};
  assign fits  = trial >= REM_W'(divisor);

  // sum at or above the divisor (or a zero divisor) means the result is MAX_LEVEL;
  // otherwise the high part of the product is below the divisor and LVL_W steps suffice
  always_ff @(posedge clk) begin
    if (load) begin
      sat <= REM_W'(sum) >= REM_W'(divisor);
      rem <= REM_W'(prod >> LVL_W);
      low <= prod[LVL_W-1:0];
      q   <= '0;
    end else if (step) begin
      rem <= fits ? (trial - REM_W'(divisor)) : trial;
      low <= low << 1;
      q   <= (q << 1) | LVL_W'(fits);
    end
  end

  assign quotient = sat ? MaxCode : q;

endmodule

// File: src/hem_dp.sv
// datapath: configuration registers, running sums, bin counter, three dividers
// and the output register; driven by hem_ctrl commands, depends on hem_pkg and hem_div
module hem_dp #(
  parameter int MAX_LEVEL  = 255,
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  hem_pkg::hem_cmd_t              cmd,
  input  logic                           cfg_valid,
  input  logic [hem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hem_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [hem_pkg::IN_W-1:0]       red_count,
  input  logic [hem_pkg::IN_W-1:0]       green_count,
  input  logic [hem_pkg::IN_W-1:0]       blue_count,
  output logic [hem_pkg::LVL_OUT_W-1:0]  level_index,
  output logic [hem_pkg::LVL_OUT_W-1:0]  red_level,
  output logic [hem_pkg::LVL_OUT_W-1:0]  green_level,
  output logic [hem_pkg::LVL_OUT_W-1:0]  blue_level,
  output logic                           last_entry
);
  import hem_pkg::*;

  localparam int SUM_W = COUNT_BITS + 1;
  localparam int LVL_W = $clog2(MAX_LEVEL + 1);
  localparam int ADD_W = ((SUM_W > IN_W) ? SUM_W : IN_W) + 1;
  localparam logic [SUM_W-1:0] SumMax = {SUM_W{1'b1}};

  logic [EN_W-1:0]      enable;
  logic [PC_W-1:0]      pixel_count;
  logic [EN_W-1:0]      enable_snap;
  logic [LVL_W-1:0]     counter;
  logic [LVL_W-1:0]     level;
  logic                 last;
  logic [IN_W-1:0]      count [NUM_CH];
  logic [LVL_OUT_W-1:0] lvl_out [NUM_CH];

  assign count[0] = red_count;
  assign count[1] = green_count;
  assign count[2] = blue_count;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= ENABLE_RESET;
      pixel_count <= PIXEL_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNEL_ENABLE: enable      <= cfg_data[EN_W-1:0];
        REG_PIXEL_COUNT:    pixel_count <= cfg_data[PC_W-1:0];
        default: ;
      endcase
    end
  end

  // bin counter wraps after the highest level
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (cmd.accept) begin
      counter <= (counter >= LVL_W'(MAX_LEVEL)) ? '0 : counter + LVL_W'(1);
    end
  end

  // per-transaction snapshot of level, last mark and enables
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      level       <= counter;
      last        <= counter >= LVL_W'(MAX_LEVEL);
      enable_snap <= enable;
    end
  end

  // one running sum and divider per color channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [SUM_W-1:0] sum;
    logic [ADD_W-1:0] total;
    logic [SUM_W-1:0] sum_next;
    logic [LVL_W-1:0] quo;

    // saturating accumulate
    assign total    = ADD_W'(sum) + ADD_W'(count[c]);
    assign sum_next = (|(total >> SUM_W)) ? SumMax : total[SUM_W-1:0];

    // sums clear once the last bin has been handed to the divider
    always_ff @(posedge clk) begin
      if (rst) begin
        sum <= '0;
      end else if (cmd.accept && enable[c]) begin
        sum <= sum_next;
      end else if (cmd.start && last) begin
        sum <= '0;
      end
    end

    hem_div #(
      .MAX_LEVEL (MAX_LEVEL),
      .SUM_W     (SUM_W)
    ) u_div (
      .clk      (clk),
      .load     (cmd.start),
      .step     (cmd.step),
      .sum      (sum),
      .divisor  (pixel_count),
      .quotient (quo)
    );

    // output register, zero for a disabled channel
    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        lvl_out[c] <= enable_snap[c] ? LVL_OUT_W'(quo) : '0;
      end
    end
  end

  // output register for index and last mark
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level_index <= LVL_OUT_W'(level);
      last_entry  <= last;
    end
  end

  assign red_level   = lvl_out[0];
  assign green_level = lvl_out[1];
  assign blue_level  = lvl_out[2];

endmodule

// File: src/hem_ctrl.sv
// controller: sequences accept, scale, divide and output load for one bin at a time
// and owns both handshakes; depends on hem_pkg
module hem_ctrl #(
  parameter int MAX_LEVEL = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hem_pkg::hem_cmd_t cmd
);
  import hem_pkg::*;

  localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int STEP_W = $clog2(LVL_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;
  logic              out_valid_next;

  // commands
  assign in_ready     = (state == ST_IDLE);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.start    = (state == ST_MUL);
  assign cmd.step     = (state == ST_DIV);
  assign cmd.out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) state_next = ST_MUL;
      end
      ST_MUL: begin
        step_cnt_next = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(LVL_W - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (cmd.out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output valid holds until the receiver takes the entry
  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  // a taken bin starts the scaling cycle and blocks further input
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_MUL) && !in_ready)
    else $error("accepted bin did not start scaling");

  // the divide step count never passes the quotient width
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step_cnt < STEP_W'(LVL_W)))
    else $error("divide step count out of range");

  // an entry is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output entry overwritten");

  // a loaded entry is presented next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded entry not presented");
`endif

endmodule

// File: src/histogram_equalization_map.sv
// top level of the histogram equalization map block
// depends on hem_pkg, the channel interfaces, hem_ctrl, hem_dp and hem_div
//
// Usage:
//   hist : one transaction per histogram bin, levels 0 to MAX_LEVEL in order,
//          carrying the red, green and blue counts of that level.
//   lut  : one transaction per bin with the level index, the equalized red,
//          green and blue levels (0 for a disabled channel) and last_entry
//          set on the entry for level MAX_LEVEL.
//   cfg  : register writes, always ready; index 0 channel enable, index 1
//          pixel count. Write only while no bin is in flight.
// Timing:
//   a bin is accepted, scaled and divided by the bit-per-cycle restoring
//   dividers, and its entry loaded into the output register, before the
//   next bin is accepted.
//   The output register lets the next bin be accepted while an entry waits;
//   a stalled receiver holds the finished entry and then the next one stops
//   before its output load, so nothing is dropped.
// Reset:
//   sums and bin counter clear, channel enable returns to all three channels,
//   pixel count to one; no entry is pending.
module histogram_equalization_map #(
  parameter int MAX_LEVEL  = 255,
  parameter int COUNT_BITS = 24
) (
  input logic       clk,
  input logic       rst,
  hem_hist_if.sink  hist,
  hem_lut_if.source lut,
  hem_cfg_if.sink   cfg
);
  import hem_pkg::*;

  hem_cmd_t cmd;

  // register writes are taken at once
  assign cfg.ready = 1'b1;

  hem_ctrl #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hist.valid),
    .in_ready  (hist.ready),
    .out_valid (lut.valid),
    .out_ready (lut.ready),
    .cmd       (cmd)
  );

  hem_dp #(
    .MAX_LEVEL  (MAX_LEVEL),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .red_count   (hist.red_count),
    .green_count (hist.green_count),
    .blue_count  (hist.blue_count),
    .level_index (lut.level_index),
    .red_level   (lut.red_level),
    .green_level (lut.green_level),
    .blue_level  (lut.blue_level),
    .last_entry  (lut.last_entry)
  );

endmodule
